>>> hw/rtl/telecommand_frame_builder_crc32_macros.svh
// assertion macros used by the back end of the frame builder rtl
// expects clk and rst_n in the scope of each use
`ifndef TELECOMMAND_FRAME_BUILDER_CRC32_MACROS_SVH
`define TELECOMMAND_FRAME_BUILDER_CRC32_MACROS_SVH

// same-cycle implication
`define TCFB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tcfb_pkg.sv
// shared types, constants and crc helper for the telecommand frame builder
// no dependencies
`timescale 1ns / 1ps

package tcfb_pkg;

  localparam int unsigned LEN_W      = 16;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);
  localparam int unsigned HDR_BYTES  = 12;
  localparam int unsigned TRL_BYTES  = 8;
  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [31:0] FRAME_OVHD = 32'd20;
  localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(2);

  // configuration register indexes
  localparam logic [1:0] REG_PREAMBLE  = 2'd0;
  localparam logic [1:0] REG_POSTAMBLE = 2'd1;
  localparam logic [1:0] REG_MSG_TYPE  = 2'd2;
  localparam logic [1:0] REG_CRC_POLY  = 2'd3;

  localparam logic [31:0] RST_PREAMBLE  = 32'h0000_0000;
  localparam logic [31:0] RST_POSTAMBLE = 32'h0000_0000;
  localparam logic [31:0] RST_MSG_TYPE  = 32'h0000_0001;
  localparam logic [31:0] RST_CRC_POLY  = 32'hEDB8_8320;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [15:0] payload_length;
  } in_word_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       run_last;
  } out_word_t;

  typedef struct packed {
    logic [31:0] preamble_word;
    logic [31:0] postamble_word;
    logic [31:0] message_type;
    logic [31:0] crc_polynomial;
  } cfg_regs_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [7:0]       pbyte;
    logic             first;
    logic             last;
    logic [LEN_W-1:0] len;
  } qent_t;

  // one byte through the reflected crc, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data,
                                           input logic [31:0] poly);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ poly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/tcfb_front.sv
// front end: accepts payload words and marks frame start and end
// depends on tcfb_pkg
`timescale 1ns / 1ps

module tcfb_front
  import tcfb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_data,
  output logic     q_push,
  output qent_t    q_wdata,
  input  logic     q_full
);

  logic             in_frame_r, in_frame_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [LEN_W-1:0] len_raw, len_adj;
  logic             accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  assign len_raw = in_data.payload_length[LEN_W-1:0];
  assign len_adj = (len_raw < MIN_LEN) ? MIN_LEN : len_raw;

  always_comb begin
    in_frame_nxt      = in_frame_r;
    rem_nxt           = rem_r;
    q_wdata.pbyte     = in_data.payload_byte;
    q_wdata.len       = len_adj;
    q_wdata.first     = !in_frame_r;
    q_wdata.last      = 1'b0;
    if (!in_frame_r) begin
      // frames carry at least two bytes, so a first word never closes one
      rem_nxt = len_adj - LEN_W'(1);
    end else begin
      rem_nxt      = rem_r - LEN_W'(1);
      q_wdata.last = (rem_nxt == '0);
    end
    in_frame_nxt = !q_wdata.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      rem_r      <= '0;
    end else if (accept) begin
      in_frame_r <= in_frame_nxt;
      rem_r      <= rem_nxt;
    end
  end

endmodule

>>> hw/rtl/tcfb_queue.sv
// small register queue between the front and back ends
// depends on tcfb_pkg
`timescale 1ns / 1ps

module tcfb_queue
  import tcfb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t wdata,
  output logic  full,
  input  logic  pop,
  output logic  rvalid,
  output qent_t rdata
);

  qent_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full   = (cnt_r == QCNT_W'(QDEPTH));
  assign rvalid = (cnt_r != '0);
  assign rdata  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/tcfb_back.sv
// back end: expands queued words into header, payload and trailer bytes
// depends on tcfb_pkg and the assertion macros header
`timescale 1ns / 1ps

`include "telecommand_frame_builder_crc32_macros.svh"

module tcfb_back
  import tcfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t cfg,
  input  logic      q_valid,
  input  qent_t     q_rdata,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  typedef enum logic [1:0] {PH_HDR, PH_PAY, PH_TRL} phase_t;

  phase_t      phase_r, phase_nxt, eff_phase;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] crc_r, crc_nxt, crc_base, crc_out;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_data_r, out_data_nxt;
  logic        emit;
  logic [31:0] hdr_word, trl_word;
  logic [7:0]  hdr_byte, trl_byte;

  // a word that does not open a frame skips the header
  assign eff_phase = (phase_r == PH_HDR && !q_rdata.first) ? PH_PAY : phase_r;
  assign emit      = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    case (cnt_r[3:2])
      2'd0:    hdr_word = cfg.preamble_word;
      2'd1:    hdr_word = {{(32-LEN_W){1'b0}}, q_rdata.len} + FRAME_OVHD;
      default: hdr_word = cfg.message_type;
    endcase
    hdr_byte = hdr_word[8*cnt_r[1:0] +: 8];
    trl_word = cnt_r[2] ? cfg.postamble_word : (crc_r ^ ALL_ONES);
    trl_byte = trl_word[8*cnt_r[1:0] +: 8];
  end

  // header restarts the crc from all ones
  assign crc_base = (eff_phase == PH_HDR && cnt_r == '0) ? ALL_ONES : crc_r;
  assign crc_out  = crc_byte(crc_base,
                             (eff_phase == PH_HDR) ? hdr_byte : q_rdata.pbyte,
                             cfg.crc_polynomial);

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    crc_nxt       = crc_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;
    if (emit) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.frame_end = 1'b0;
      out_data_nxt.run_last  = 1'b0;
      case (eff_phase)
        PH_HDR: begin
          out_data_nxt.frame_byte = hdr_byte;
          crc_nxt                 = crc_out;
          if (cnt_r == 4'(HDR_BYTES - 1)) begin
            phase_nxt = PH_PAY;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 4'd1;
          end
        end
        PH_PAY: begin
          out_data_nxt.frame_byte = q_rdata.pbyte;
          crc_nxt                 = crc_out;
          cnt_nxt                 = '0;
          if (q_rdata.last) begin
            phase_nxt = PH_TRL;
          end else begin
            phase_nxt             = PH_HDR;
            out_data_nxt.run_last = 1'b1;
            q_pop                 = 1'b1;
          end
        end
        PH_TRL: begin
          out_data_nxt.frame_byte = trl_byte;
          if (cnt_r == 4'(TRL_BYTES - 1)) begin
            out_data_nxt.frame_end = 1'b1;
            out_data_nxt.run_last  = 1'b1;
            phase_nxt              = PH_HDR;
            cnt_nxt                = '0;
            crc_nxt                = ALL_ONES;
            q_pop                  = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 4'd1;
          end
        end
        default: begin
          phase_nxt = PH_HDR;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR;
      cnt_r       <= '0;
      crc_r       <= ALL_ONES;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TCFB_ASSERT_NOW(a_end_is_last, out_valid_r && out_data_r.frame_end, out_data_r.run_last, "frame end without run end")
  `TCFB_ASSERT_NOW(a_trl_on_last, q_valid && phase_r == PH_TRL, q_rdata.last, "trailer on a word that does not close a frame")
  `TCFB_ASSERT_NOW(a_hdr_cnt, phase_r == PH_HDR, cnt_r < 4'(HDR_BYTES), "header counter out of range")
  `TCFB_ASSERT_NOW(a_pop_emit, q_pop, emit, "queue pop without an emitted byte")

endmodule

>>> hw/rtl/telecommand_frame_builder_crc32.sv
// channel  | dir | handshake          | payload
// in_      | in  | in_valid/in_stall  | in_word_t (payload_byte, payload_length)
// out_     | out | out_valid/out_stall| out_word_t (frame_byte, frame_end, run_last)
// cfg_     | in  | cfg_valid/cfg_ready| cfg_index, cfg_wdata
//
// a middle payload word gives one byte, a first word adds the header bytes
// and a last word the trailer, via the single byte output register of the back end
// a four-word queue lets the front keep taking words while the back expands runs
// reset is synchronous and needs no clearing pass; config returns to defaults
// out_stall holds the output register, in_stall rises only when the queue is full
// top level of the telecommand frame builder, holds the config registers
// depends on tcfb_pkg, tcfb_front, tcfb_queue and tcfb_back
`timescale 1ns / 1ps

module telecommand_frame_builder_crc32
  import tcfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cfg_regs_t cfg_r;
  logic      q_push, q_full, q_pop, q_valid;
  qent_t     q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preamble_word  <= RST_PREAMBLE;
      cfg_r.postamble_word <= RST_POSTAMBLE;
      cfg_r.message_type   <= RST_MSG_TYPE;
      cfg_r.crc_polynomial <= RST_CRC_POLY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PREAMBLE:  cfg_r.preamble_word  <= cfg_wdata;
        REG_POSTAMBLE: cfg_r.postamble_word <= cfg_wdata;
        REG_MSG_TYPE:  cfg_r.message_type   <= cfg_wdata;
        REG_CRC_POLY:  cfg_r.crc_polynomial <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tcfb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  tcfb_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  tcfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> bench/frame_builder_checker.sv
// checker for the telecommand frame builder: watches the config, input and output channels,
// predicts the outgoing frame words and compares them in order; depends on tcfb_pkg
`timescale 1ns / 1ps

module frame_builder_checker
  import tcfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_word_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  logic [31:0] preamble_q;
  logic [31:0] postamble_q;
  logic [31:0] msg_type_q;
  logic [31:0] poly_q;

  logic [31:0] crc_acc;
  logic [15:0] left_cnt;
  logic        framing;
  logic [15:0] len_v;

  out_word_t   run_q[$];
  out_word_t   frame_bytes_due[$];
  out_word_t   want;
  int          fails = 0;

  // reflected crc, one bit per shift, poly folded in when a one falls out
  function automatic logic [31:0] crc_next(input logic [31:0] crc, input logic [7:0] data,
                                           input logic [31:0] poly);
    logic [31:0] acc;
    logic        lsb;
    acc = crc ^ {24'd0, data};
    repeat (8) begin
      lsb = acc[0];
      acc = {1'b0, acc[31:1]};
      if (lsb) begin
        acc = acc ^ poly;
      end
    end
    return acc;
  endfunction

  task add_byte(input logic [7:0] b, input logic ends_frame);
    out_word_t w;
    w.frame_byte = b;
    w.frame_end  = ends_frame;
    w.run_last   = 1'b0;
    run_q.push_back(w);
  endtask

  // header words go through the crc, little-endian
  task add_crc_word(input logic [31:0] word);
    for (int i = 0; i < 4; i++) begin
      crc_acc = crc_next(crc_acc, word[8*i +: 8], poly_q);
      add_byte(word[8*i +: 8], 1'b0);
    end
  endtask

  task add_plain_word(input logic [31:0] word, input logic closes);
    for (int i = 0; i < 4; i++) begin
      add_byte(word[8*i +: 8], closes && (i == 3));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      preamble_q  = RST_PREAMBLE;
      postamble_q = RST_POSTAMBLE;
      msg_type_q  = RST_MSG_TYPE;
      poly_q      = RST_CRC_POLY;
      crc_acc     = ALL_ONES;
      left_cnt    = '0;
      framing     = 1'b0;
      frame_bytes_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PREAMBLE:  preamble_q  = cfg_wdata;
          REG_POSTAMBLE: postamble_q = cfg_wdata;
          REG_MSG_TYPE:  msg_type_q  = cfg_wdata;
          REG_CRC_POLY:  poly_q      = cfg_wdata;
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        run_q.delete();
        if (!framing) begin
          // length field is exactly the counter width, so no truncation here
          len_v = in_data.payload_length;
          if (len_v < MIN_LEN) begin
            len_v = MIN_LEN;
          end
          crc_acc = ALL_ONES;
          add_crc_word(preamble_q);
          add_crc_word({16'd0, len_v} + FRAME_OVHD);
          add_crc_word(msg_type_q);
          left_cnt = len_v;
          framing  = 1'b1;
        end
        crc_acc = crc_next(crc_acc, in_data.payload_byte, poly_q);
        add_byte(in_data.payload_byte, 1'b0);
        left_cnt = left_cnt - 16'd1;
        if (left_cnt == '0) begin
          add_plain_word(crc_acc ^ ALL_ONES, 1'b0);
          add_plain_word(postamble_q, 1'b1);
          crc_acc = ALL_ONES;
          framing = 1'b0;
        end
        run_q[run_q.size() - 1].run_last = 1'b1;
        foreach (run_q[i]) begin
          frame_bytes_due.push_back(run_q[i]);
        end
      end

      if (out_valid && !out_stall) begin
        if (frame_bytes_due.size() == 0) begin
          $error("unexpected output word: frame_byte %02h frame_end %0b run_last %0b",
                 out_data.frame_byte, out_data.frame_end, out_data.run_last);
          fails++;
        end else begin
          want = frame_bytes_due.pop_front();
          if (out_data.frame_byte !== want.frame_byte) begin
            $error("frame_byte expected %02h actual %02h", want.frame_byte, out_data.frame_byte);
            fails++;
          end
          if (out_data.frame_end !== want.frame_end) begin
            $error("frame_end expected %0b actual %0b", want.frame_end, out_data.frame_end);
            fails++;
          end
          if (out_data.run_last !== want.run_last) begin
            $error("run_last expected %0b actual %0b", want.run_last, out_data.run_last);
            fails++;
          end
        end
      end
    end
    fail_count <= fails;
    pending    <= frame_bytes_due.size();
  end

endmodule

>>> bench/tb_top.sv
// top of the frame builder bench: clock, reset, stimulus, config phases and verdict
// depends on tcfb_pkg, telecommand_frame_builder_crc32 and frame_builder_checker
`timescale 1ns / 1ps

module tb_top
  import tcfb_pkg::*;
();

  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_ITEMS  = 90;
  localparam int TAIL_CYCLES  = 24;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  int fail_count;
  int pending;
  int tx_idle_pct;
  int rx_idle_pct;
  int cycle_count = 0;
  int items_sent;
  int pick;
  logic [15:0] frame_len;

  telecommand_frame_builder_crc32 dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  frame_builder_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("telecommand_frame_builder_crc32 regression: fail");
      $finish;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic [15:0] len);
    in_word_t w;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    w.payload_byte   = b;
    w.payload_length = len;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  // first word carries the length, the rest carry noise in the ignored length field
  task automatic send_frame(input logic [15:0] len);
    int count;
    count = (len < 16'd2) ? 2 : int'(len);
    send_word(8'($urandom_range(0, 255)), len);
    for (int i = 1; i < count; i++) begin
      send_word(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    end
  endtask

  // advance the clock before polling so the count covers the word accepted just before
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
  endtask

  task automatic load_config(input logic [31:0] pre, input logic [31:0] post,
                             input logic [31:0] msg, input logic [31:0] poly);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    cfg_write(REG_PREAMBLE, pre);
    cfg_write(REG_POSTAMBLE, post);
    cfg_write(REG_MSG_TYPE, msg);
    cfg_write(REG_CRC_POLY, poly);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= REG_PREAMBLE;
    cfg_wdata   <= '0;
    items_sent   = 0;
    tx_idle_pct  = 21;
    rx_idle_pct  = 75;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset config: short lengths raised to two, byte extremes
    send_word(8'h00, 16'd0);
    send_word(8'hFF, 16'hFFFF);
    send_word(8'hFF, 16'd1);
    send_word(8'h00, 16'h0000);
    send_word(8'h80, 16'd2);
    send_word(8'h01, 16'hAAAA);
    send_word(8'hAA, 16'd5);
    send_word(8'h55, 16'h5555);
    send_word(8'h7F, 16'hFFFF);
    send_word(8'hFE, 16'h0001);
    send_word(8'h00, 16'h8000);
    send_frame(16'd3);
    drain_results();

    for (int phase = 1; phase <= 5; phase++) begin
      case (phase)
        1: load_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        2: load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: load_config($urandom, $urandom, $urandom, RST_CRC_POLY);
        4: load_config($urandom, $urandom, $urandom, 32'h04C1_1DB7);
        default: load_config($urandom, $urandom, $urandom, $urandom);
      endcase
      if (phase >= 5) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (phase >= 3) begin
        tx_idle_pct = 75;
        rx_idle_pct = 21;
      end
      while (items_sent < 12 + phase * PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          frame_len = 16'($urandom_range(0, 1));
        end else if (pick < 75) begin
          frame_len = 16'($urandom_range(2, 8));
        end else if (pick < 95) begin
          frame_len = 16'($urandom_range(9, 24));
        end else begin
          frame_len = 16'($urandom_range(25, 64));
        end
        send_frame(frame_len);
        // now and then hold off until the output side has emptied
        if ($urandom_range(0, 11) == 0) begin
          drain_results();
        end
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("telecommand_frame_builder_crc32 regression: pass");
    end else begin
      $display("telecommand_frame_builder_crc32 regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/tcfb_pkg.sv
hw/rtl/tcfb_front.sv
hw/rtl/tcfb_queue.sv
hw/rtl/tcfb_back.sv
hw/rtl/telecommand_frame_builder_crc32.sv
bench/frame_builder_checker.sv
bench/tb_top.sv
